FILE: hdl/dars_pkg.sv
package dars_pkg;

   // Queue geometry
   localparam int QUEUE_DEPTH = 64;
   localparam int NUM_UNITS   = 2;
   localparam int TRACK_BITS  = 16;
   localparam int SLOT_BITS   = 6;
   localparam int IDX_BITS    = $clog2(QUEUE_DEPTH);
   localparam int LEN_BITS    = $clog2(QUEUE_DEPTH + 1);
   localparam int MEM_DEPTH   = NUM_UNITS * QUEUE_DEPTH;
   localparam int ADDR_BITS   = $clog2(MEM_DEPTH);

   // Operation and mode codes
   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;
   localparam logic MODE_FCFS  = 1'b0;
   localparam logic MODE_SSTF  = 1'b1;

   typedef struct packed {
      logic        operation;
      logic        disk_unit;
      logic [5:0]  request_slot;
      logic [15:0] request_track;
      logic [15:0] arm_track;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic        found;
      logic [5:0]  chosen_slot;
      logic [15:0] chosen_track;
   } rsp_type;

   typedef struct packed {
      logic [SLOT_BITS-1:0]  tag;
      logic [TRACK_BITS-1:0] track;
   } entry_type;

   // Shared compare unit results
   typedef struct packed {
      logic                  gt;
      logic                  less;
      logic [TRACK_BITS-1:0] span;
   } cmp_type;

endpackage

FILE: hdl/dars_cmp_unit.sv
module dars_cmp_unit (
   input  logic [dars_pkg::TRACK_BITS-1:0] entry_track,
   input  logic [dars_pkg::TRACK_BITS-1:0] key_track,
   input  logic [dars_pkg::TRACK_BITS-1:0] best_dist,
   output dars_pkg::cmp_type               result
);

   logic entry_ge;

   // Form absolute seek distance and order against key and best so far
   always_comb begin
      entry_ge    = entry_track >= key_track;
      result.gt   = entry_track > key_track;
      result.span = entry_ge ? (entry_track - key_track) : (key_track - entry_track);
      result.less = result.span < best_dist;
   end

endmodule

FILE: hdl/disk_arm_request_scheduler.sv
// Disk arm request scheduler: one ordered request queue per disk unit, held in a single
// entry memory with one write and one registered read port. An enqueue (FCFS: tail; SSTF:
// before the first entry with a greater track) or a dequeue (FCFS: head; SSTF: first entry
// with the smallest distance to the arm track) each produce exactly one response beat.
// Each item is taken in idle, then runs a scan pass over the entries (the whole queue for
// an SSTF dequeue, up to the insert point for an SSTF enqueue, one for a FCFS dequeue,
// none for a FCFS enqueue), a move pass that opens or closes a gap where one is needed,
// the store of a new entry on an enqueue, and a response state; the worst case is an SSTF
// dequeue of a full queue that takes the head. Both passes are paced by the single read
// port of the entry memory, which serves one entry per cycle for both the scan and the
// move. req_ready is high only while no item is in work; a finished response waits in its
// output register while the next request is taken. csr_wr_data sets the scheduling mode
// (0 FCFS, 1 SSTF, SSTF after reset); the user must write it only while idle, which the
// block itself does not enforce.
module disk_arm_request_scheduler (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dars_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dars_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_SHUP  = 3'd2;
   localparam logic [2:0] ST_SHDN  = 3'd3;
   localparam logic [2:0] ST_WRITE = 3'd4;
   localparam logic [2:0] ST_RESP  = 3'd5;

   localparam int LB = dars_pkg::LEN_BITS;
   localparam logic [LB-1:0] LEN_ONE  = LB'(1);
   localparam logic [LB-1:0] LEN_FULL = LB'(dars_pkg::QUEUE_DEPTH);

   logic [2:0]                      state_ff, state_in;
   logic                            mode_ff;
   logic [LB-1:0]                   len_ff [dars_pkg::NUM_UNITS];
   logic [LB-1:0]                   len_in [dars_pkg::NUM_UNITS];
   logic                            op_ff, op_in;
   logic                            unit_ff, unit_in;
   dars_pkg::entry_type             new_ff, new_in;
   logic [dars_pkg::TRACK_BITS-1:0] arm_ff, arm_in;
   logic [LB-1:0]                   cur_len_ff, cur_len_in;
   logic [LB-1:0]                   scan_len_ff, scan_len_in;
   logic [LB-1:0]                   pos_ff, pos_in;
   logic [dars_pkg::TRACK_BITS-1:0] best_dist_ff, best_dist_in;
   dars_pkg::entry_type             best_ff, best_in;
   logic [LB-1:0]                   issue_ff, issue_in;
   logic                            chk_valid_ff, chk_valid_in;
   logic [LB-1:0]                   chk_idx_ff, chk_idx_in;
   dars_pkg::rsp_type               res_ff, res_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   dars_pkg::rsp_type               rsp_data_ff, rsp_data_in;

   dars_pkg::entry_type mem [dars_pkg::MEM_DEPTH];
   dars_pkg::entry_type rd_data_ff;

   logic [LB-1:0]                   rd_idx;
   logic                            wr_en;
   logic [LB-1:0]                   wr_idx;
   dars_pkg::entry_type             wr_data;
   logic [dars_pkg::ADDR_BITS-1:0]  rd_addr, wr_addr;
   logic [dars_pkg::TRACK_BITS-1:0] key_track;
   dars_pkg::cmp_type               cmp;
   logic                            unit_ok;
   logic [LB-1:0]                   req_len;
   logic                            last;
   logic                            take;
   logic [LB-1:0]                   sel_idx;
   dars_pkg::entry_type             sel_entry;

   function automatic logic [dars_pkg::ADDR_BITS-1:0] entry_addr(
      input logic unit, input logic [LB-1:0] idx);
      entry_addr = dars_pkg::ADDR_BITS'(int'(unit) * dars_pkg::QUEUE_DEPTH
                                        + int'(idx[dars_pkg::IDX_BITS-1:0]));
   endfunction

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Shared compare: key is the arm on dequeue, the new track on enqueue
   assign key_track = (op_ff == dars_pkg::OP_DEQUEUE) ? arm_ff : new_ff.track;

   dars_cmp_unit u_cmp (
      .entry_track (rd_data_ff.track),
      .key_track   (key_track),
      .best_dist   (best_dist_ff),
      .result      (cmp)
   );

   assign rd_addr = entry_addr(unit_ff, rd_idx);
   assign wr_addr = entry_addr(unit_ff, wr_idx);

   // Entry memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      op_in        = op_ff;
      unit_in      = unit_ff;
      new_in       = new_ff;
      arm_in       = arm_ff;
      cur_len_in   = cur_len_ff;
      scan_len_in  = scan_len_ff;
      pos_in       = pos_ff;
      best_dist_in = best_dist_ff;
      best_in      = best_ff;
      issue_in     = issue_ff;
      chk_valid_in = 1'b0;
      chk_idx_in   = issue_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rd_idx       = issue_ff;
      wr_en        = 1'b0;
      wr_idx       = pos_ff;
      wr_data      = rd_data_ff;
      unit_ok      = int'(req_data.disk_unit) < dars_pkg::NUM_UNITS;
      req_len      = unit_ok ? len_ff[req_data.disk_unit] : '0;
      last         = chk_idx_ff == (scan_len_ff - LEN_ONE);
      take         = (chk_idx_ff == '0) || cmp.less;
      sel_idx      = take ? chk_idx_ff : pos_ff;
      sel_entry    = take ? rd_data_ff : best_ff;

      // Drop the response beat once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in        = req_data.operation;
               unit_in      = req_data.disk_unit;
               new_in.tag   = req_data.request_slot;
               new_in.track = dars_pkg::TRACK_BITS'(req_data.request_track);
               arm_in       = dars_pkg::TRACK_BITS'(req_data.arm_track);
               cur_len_in   = req_len;
               scan_len_in  = req_len;
               issue_in     = '0;
               res_in       = '0;
               if (!unit_ok) begin
                  state_in = ST_RESP;
               end else if (req_data.operation == dars_pkg::OP_ENQUEUE) begin
                  if (req_len >= LEN_FULL) begin
                     state_in = ST_RESP;
                  end else if (mode_ff == dars_pkg::MODE_FCFS || req_len == '0) begin
                     pos_in   = req_len;
                     state_in = ST_WRITE;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end else begin
                  if (req_len == '0) begin
                     state_in = ST_RESP;
                  end else begin
                     if (mode_ff == dars_pkg::MODE_FCFS) begin
                        scan_len_in = LEN_ONE;
                     end
                     state_in = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            // Stream one entry per cycle through the compare unit
            issue_in     = issue_ff + LEN_ONE;
            chk_valid_in = 1'b1;
            if (chk_valid_ff) begin
               if (op_ff == dars_pkg::OP_ENQUEUE) begin
                  if (cmp.gt) begin
                     pos_in       = chk_idx_ff;
                     issue_in     = cur_len_ff - LEN_ONE;
                     chk_valid_in = 1'b0;
                     state_in     = ST_SHUP;
                  end else if (last) begin
                     pos_in       = cur_len_ff;
                     chk_valid_in = 1'b0;
                     state_in     = ST_WRITE;
                  end
               end else begin
                  if (take) begin
                     pos_in       = chk_idx_ff;
                     best_dist_in = cmp.span;
                     best_in      = rd_data_ff;
                  end
                  if (last) begin
                     chk_valid_in       = 1'b0;
                     res_in.found       = 1'b1;
                     res_in.chosen_slot = 6'(sel_entry.tag);
                     res_in.chosen_track = 16'(sel_entry.track);
                     issue_in           = sel_idx + LEN_ONE;
                     if (sel_idx == cur_len_ff - LEN_ONE) begin
                        state_in = ST_RESP;
                     end else begin
                        state_in = ST_SHDN;
                     end
                  end
               end
            end
         end
         ST_SHUP: begin
            // Move entries up one place, tail first, to open the gap
            issue_in     = issue_ff - LEN_ONE;
            chk_valid_in = 1'b1;
            if (chk_valid_ff) begin
               wr_en  = 1'b1;
               wr_idx = chk_idx_ff + LEN_ONE;
               if (chk_idx_ff == pos_ff) begin
                  chk_valid_in = 1'b0;
                  state_in     = ST_WRITE;
               end
            end
         end
         ST_SHDN: begin
            // Move entries down one place to close the gap
            issue_in     = issue_ff + LEN_ONE;
            chk_valid_in = 1'b1;
            if (chk_valid_ff) begin
               wr_en  = 1'b1;
               wr_idx = chk_idx_ff - LEN_ONE;
               if (chk_idx_ff == cur_len_ff - LEN_ONE) begin
                  chk_valid_in = 1'b0;
                  state_in     = ST_RESP;
               end
            end
         end
         ST_WRITE: begin
            wr_en           = 1'b1;
            wr_idx          = pos_ff;
            wr_data         = new_ff;
            res_in.accepted = 1'b1;
            state_in        = ST_RESP;
         end
         ST_RESP: begin
            // Hand the result to the output register and commit the length
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               if (res_ff.accepted) begin
                  len_in[unit_ff] = len_ff[unit_ff] + LEN_ONE;
               end else if (res_ff.found) begin
                  len_in[unit_ff] = len_ff[unit_ff] - LEN_ONE;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= dars_pkg::MODE_SSTF;
         len_ff       <= '{default: '0};
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      unit_ff      <= unit_in;
      new_ff       <= new_in;
      arm_ff       <= arm_in;
      cur_len_ff   <= cur_len_in;
      scan_len_ff  <= scan_len_in;
      pos_ff       <= pos_in;
      best_dist_ff <= best_dist_in;
      best_ff      <= best_in;
      issue_ff     <= issue_in;
      chk_idx_ff   <= chk_idx_in;
      res_ff       <= res_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule

FILE: hdl/dars_checker.sv
module dars_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input dars_pkg::rsp_type rsp_data
);

   // Hold a stalled response beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response beat changed");

   // Busy right after taking a request beat
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an item is in work");

   // A response never both stores and returns a request
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.accepted && rsp_data.found))
      else $error("response both accepted and found");

   // Empty dequeue or enqueue reports zero slot and track
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.chosen_slot == '0 &&
                                       rsp_data.chosen_track == '0)
      else $error("nonzero slot or track without a found request");

endmodule

bind disk_arm_request_scheduler dars_checker u_dars_checker (.*);

FILE: sim/tb_disk_arm_request_scheduler.sv
module tb_disk_arm_request_scheduler;
   import dars_pkg::*;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_data    = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_data;
   logic    csr_wr_en   = 1'b0;
   logic    csr_wr_data = 1'b0;

   // Mirror of the scheduler: one ordered queue per unit plus the mode
   entry_type unit_queue[NUM_UNITS][$];
   logic      sched_mode = MODE_SSTF;

   req_type req_backlog[$];
   rsp_type sched_results[$];

   bit      idle_on = 1'b0;
   int      send_gap = 0;
   int      recv_stall = 0;
   int      fail_count = 0;
   int      rand_items = 0;
   int      stored_count = 0;
   int      refused_count = 0;
   int      served_count = 0;
   int      empty_count = 0;
   int      mode_writes = 0;
   rsp_type predicted;
   rsp_type want;

   disk_arm_request_scheduler uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one request to the mirror and return the response it must produce
   function automatic rsp_type schedule_request(req_type r);
      rsp_type        res;
      entry_type      e;
      int             pos;
      int             best;
      logic [15:0]    d;
      logic [15:0]    best_d;
      res = '0;
      best_d = '0;
      if (r.operation == OP_ENQUEUE) begin
         if (unit_queue[r.disk_unit].size() < QUEUE_DEPTH) begin
            pos = unit_queue[r.disk_unit].size();
            if (sched_mode == MODE_SSTF) begin
               pos = 0;
               while (pos < unit_queue[r.disk_unit].size() &&
                      unit_queue[r.disk_unit][pos].track <= r.request_track)
                  pos++;
            end
            e.tag   = r.request_slot;
            e.track = r.request_track;
            unit_queue[r.disk_unit].insert(pos, e);
            res.accepted = 1'b1;
         end
      end else if (unit_queue[r.disk_unit].size() != 0) begin
         best = 0;
         if (sched_mode == MODE_SSTF) begin
            // earliest entry wins a distance tie
            for (int i = 0; i < unit_queue[r.disk_unit].size(); i++) begin
               e = unit_queue[r.disk_unit][i];
               d = (e.track >= r.arm_track) ? e.track - r.arm_track : r.arm_track - e.track;
               if (i == 0 || d < best_d) begin
                  best   = i;
                  best_d = d;
               end
            end
         end
         e = unit_queue[r.disk_unit][best];
         res.found        = 1'b1;
         res.chosen_slot  = e.tag;
         res.chosen_track = e.track;
         unit_queue[r.disk_unit].delete(best);
      end
      return res;
   endfunction

   // Mostly short gaps, a few long ones, none at all in quiet phases
   function automatic int pick_delay();
      int r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 20);
      return $urandom_range(50, 200);
   endfunction

   // Extremes and a tight cluster for distance ties, otherwise anything
   function automatic logic [15:0] pick_track();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 16'h0000;
      if (r == 1) return 16'hFFFF;
      if (r < 5) return 16'($urandom_range(0, 15));
      return 16'($urandom);
   endfunction

   function automatic void add_req(logic op, logic unit, logic [5:0] slot,
                                   logic [15:0] trk, logic [15:0] arm);
      req_type r;
      r.operation     = op;
      r.disk_unit     = unit;
      r.request_slot  = slot;
      r.request_track = trk;
      r.arm_track     = arm;
      req_backlog.push_back(r);
   endfunction

   // Hold off until every beat is answered, then let the block settle
   task automatic wait_drained();
      do @(negedge clock);
      while (req_backlog.size() != 0 || req_valid || sched_results.size() != 0);
      repeat (2 * QUEUE_DEPTH + 8) @(negedge clock);
   endtask

   task automatic set_mode(logic m);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      sched_mode = m;
      mode_writes++;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // Driver: advance the backlog one beat at a time, predict on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            predicted = schedule_request(req_data);
            sched_results.push_back(predicted);
            if (req_data.operation == OP_ENQUEUE) begin
               if (predicted.accepted) stored_count++;
               else refused_count++;
            end else begin
               if (predicted.found) served_count++;
               else empty_count++;
            end
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (req_backlog.size() != 0) begin
               req_data  <= req_backlog.pop_front();
               req_valid <= 1'b1;
               send_gap = pick_delay();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each response beat against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (sched_results.size() == 0) begin
               $error("response beat with no request outstanding");
               fail_count++;
            end else begin
               want = sched_results.pop_front();
               if (rsp_data.accepted !== want.accepted) begin
                  $error("accepted: expected %0d, got %0d", want.accepted, rsp_data.accepted);
                  fail_count++;
               end
               if (rsp_data.found !== want.found) begin
                  $error("found: expected %0d, got %0d", want.found, rsp_data.found);
                  fail_count++;
               end
               if (rsp_data.chosen_slot !== want.chosen_slot) begin
                  $error("chosen_slot: expected %0d, got %0d",
                         want.chosen_slot, rsp_data.chosen_slot);
                  fail_count++;
               end
               if (rsp_data.chosen_track !== want.chosen_track) begin
                  $error("chosen_track: expected %0d, got %0d",
                         want.chosen_track, rsp_data.chosen_track);
                  fail_count++;
               end
            end
            recv_stall = pick_delay();
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      int  phase_no;
      int  kind;
      int  count;
      int  enq_pct;
      logic home_unit;
      logic unit;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // SSTF after reset: empty queue, extremes, equal tracks, distance tie
      add_req(OP_DEQUEUE, 1'b0, 6'd0,  16'h0000, 16'h0000);
      add_req(OP_ENQUEUE, 1'b0, 6'd63, 16'hFFFF, 16'h0000);
      add_req(OP_ENQUEUE, 1'b0, 6'd0,  16'h0000, 16'hFFFF);
      add_req(OP_ENQUEUE, 1'b0, 6'd5,  16'd100,  16'h0000);
      add_req(OP_ENQUEUE, 1'b0, 6'd6,  16'd100,  16'h0000);
      add_req(OP_ENQUEUE, 1'b0, 6'd7,  16'd300,  16'h0000);
      add_req(OP_ENQUEUE, 1'b1, 6'd42, 16'h8000, 16'h0000);
      add_req(OP_DEQUEUE, 1'b0, 6'd0,  16'h0000, 16'd200);
      add_req(OP_DEQUEUE, 1'b0, 6'd0,  16'h0000, 16'hFFFF);
      add_req(OP_DEQUEUE, 1'b0, 6'd0,  16'h0000, 16'h0000);
      add_req(OP_DEQUEUE, 1'b1, 6'd0,  16'h0000, 16'h7FFF);
      add_req(OP_DEQUEUE, 1'b1, 6'd63, 16'hFFFF, 16'hFFFF);
      wait_drained();

      // FCFS: tail insert, head removal regardless of arm
      set_mode(MODE_FCFS);
      add_req(OP_ENQUEUE, 1'b0, 6'd1, 16'd900, 16'h0000);
      add_req(OP_ENQUEUE, 1'b0, 6'd2, 16'd10,  16'h0000);
      add_req(OP_ENQUEUE, 1'b0, 6'd3, 16'd500, 16'h0000);
      add_req(OP_ENQUEUE, 1'b0, 6'd4, 16'd50,  16'h0000);
      add_req(OP_DEQUEUE, 1'b0, 6'd0, 16'h0000, 16'd10);
      wait_drained();

      // Switch to SSTF with an unsorted queue left in place
      set_mode(MODE_SSTF);
      add_req(OP_ENQUEUE, 1'b0, 6'd8, 16'd60, 16'h0000);
      add_req(OP_DEQUEUE, 1'b0, 6'd0, 16'h0000, 16'd55);
      add_req(OP_DEQUEUE, 1'b0, 6'd0, 16'h0000, 16'd52);
      add_req(OP_DEQUEUE, 1'b0, 6'd0, 16'h0000, 16'h0000);
      add_req(OP_DEQUEUE, 1'b0, 6'd0, 16'h0000, 16'h0000);
      wait_drained();

      // Random phases: mixed, filling past full, draining
      phase_no = 0;
      while (rand_items < 1600) begin
         if (phase_no == 0) set_mode(MODE_FCFS);
         else if (phase_no == 1) set_mode(MODE_SSTF);
         else set_mode(1'($urandom_range(0, 1)));
         kind = (phase_no < 3) ? (phase_no + 1) % 3 : $urandom_range(0, 2);
         idle_on = ($urandom_range(0, 3) != 0);
         enq_pct = (kind == 1) ? 85 : (kind == 2) ? 20 : 55;
         home_unit = 1'($urandom_range(0, 1));
         count = $urandom_range(60, 140);
         for (int i = 0; i < count; i++) begin
            unit = ($urandom_range(0, 99) < 80) ? home_unit : 1'($urandom_range(0, 1));
            add_req(($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE, unit,
                    6'($urandom_range(0, 63)), pick_track(), pick_track());
         end
         rand_items += count;
         phase_no++;
         wait_drained();
      end

      if (sched_results.size() != 0) begin
         $error("%0d responses never arrived", sched_results.size());
         fail_count++;
      end
      $display("Ran %0d random requests in %0d phases with %0d mode writes",
               rand_items, phase_no, mode_writes);
      $display("Stored %0d, refused when full %0d, served %0d, empty dequeues %0d",
               stored_count, refused_count, served_count, empty_count);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Hard stop well beyond the slowest correct run
   initial begin
      #40_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
